FILE: rtl/atpq_pkg.sv
// ----------------------------------------------------------------------------
// Task priority queue package
// Shared sizes, command codes, cell entry type and chain operation type.
// ----------------------------------------------------------------------------
`default_nettype none

package atpq_pkg;

    // Number of task slots, which is also the number of cells in the chain.
    localparam int unsigned TASK_SLOTS = 256;
    localparam int unsigned SLOT_AW    = $clog2(TASK_SLOTS);

    // Field widths of the words on the ports.
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned ID_W    = 8;
    localparam int unsigned OWNER_W = 16;
    localparam int unsigned PRIO_W  = 32;

    // Sort key is priority first, then task id.
    localparam int unsigned KEY_W = PRIO_W + SLOT_AW;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_EDIT   = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_EXEC   = 2'd3
    } cmd_t;

    // One pending task as held by a cell.
    typedef struct packed {
        logic               valid;
        logic [PRIO_W-1:0]  prio;
        logic [SLOT_AW-1:0] id;
        logic [OWNER_W-1:0] owner;
    } entry_t;

    localparam entry_t ENTRY_EMPTY = '0;

    // Operation broadcast to every cell of the chain.
    typedef enum logic [1:0] {
        CH_HOLD   = 2'd0,
        CH_INSERT = 2'd1,
        CH_REMOVE = 2'd2,
        CH_POP    = 2'd3
    } chain_kind_t;

    typedef struct packed {
        chain_kind_t        kind;
        logic [PRIO_W-1:0]  prio;
        logic [SLOT_AW-1:0] id;
        logic [OWNER_W-1:0] owner;
    } chain_op_t;

endpackage

`default_nettype wire

FILE: rtl/atpq_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module atpq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/atpq_cell.sv
// ----------------------------------------------------------------------------
// Task priority queue cell
// Holds one entry of the sorted chain and trades it with its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module atpq_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire atpq_pkg::chain_op_t op,
    input  wire atpq_pkg::entry_t    prev_entry,
    input  wire logic                prev_free,
    input  wire atpq_pkg::entry_t    next_entry,
    output atpq_pkg::entry_t         entry,
    output logic                     free
);

    import atpq_pkg::*;

    entry_t           entry_reg;
    entry_t           entry_next;
    entry_t           new_entry;
    logic [KEY_W-1:0] own_key;
    logic [KEY_W-1:0] op_key;
    logic             key_lt;
    logic             key_eq;

    // Compare the held key with the broadcast key.
    assign own_key = {entry_reg.prio, entry_reg.id};
    assign op_key  = {op.prio, op.id};
    assign key_lt  = (own_key < op_key);
    assign key_eq  = (own_key == op_key);

    // The cell ranks below a new word when empty or holding a smaller key.
    assign free = !entry_reg.valid || key_lt;

    always_comb
    begin
        new_entry.valid = 1'b1;
        new_entry.prio  = op.prio;
        new_entry.id    = op.id;
        new_entry.owner = op.owner;
    end

    // Insert shifts down from the insertion point, remove and pop shift up.
    always_comb
    begin
        entry_next = entry_reg;
        unique case (op.kind)
            CH_INSERT:
            begin
                if (free)
                begin
                    entry_next = prev_free ? prev_entry : new_entry;
                end
            end
            CH_REMOVE:
            begin
                if (entry_reg.valid && (key_lt || key_eq))
                begin
                    entry_next = next_entry;
                end
            end
            CH_POP:
            begin
                entry_next = next_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= ENTRY_EMPTY;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

FILE: rtl/atpq_chain.sv
// ----------------------------------------------------------------------------
// Task priority queue chain
// A row of cells kept sorted by descending priority, then descending id.
// ----------------------------------------------------------------------------
`default_nettype none

module atpq_chain (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire atpq_pkg::chain_op_t op,
    output atpq_pkg::entry_t         head
);

    import atpq_pkg::*;

    entry_t                cell_entry [TASK_SLOTS];
    logic [TASK_SLOTS-1:0] cell_free;

    // Build the row; the ends see an empty neighbor.
    for (genvar i = 0; i < TASK_SLOTS; i++)
    begin : g_cell
        entry_t up_entry;
        logic   up_free;
        entry_t down_entry;

        if (i == 0)
        begin : g_first
            assign up_entry = ENTRY_EMPTY;
            assign up_free  = 1'b0;
        end
        else
        begin : g_inner
            assign up_entry = cell_entry[i-1];
            assign up_free  = cell_free[i-1];
        end

        if (i == TASK_SLOTS - 1)
        begin : g_last
            assign down_entry = ENTRY_EMPTY;
        end
        else
        begin : g_body
            assign down_entry = cell_entry[i+1];
        end

        atpq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .op         (op),
            .prev_entry (up_entry),
            .prev_free  (up_free),
            .next_entry (down_entry),
            .entry      (cell_entry[i]),
            .free       (cell_free[i])
        );
    end

    assign head = cell_entry[0];

endmodule

`default_nettype wire

FILE: rtl/addressable_task_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// Addressable task priority queue unit
// Pending tasks sit in a sorted chain of cells; a slot RAM indexed by task
// id keeps each task's owner and priority so a task can be found by key.
// ----------------------------------------------------------------------------
//
//  Channel  Signals                                        Direction
//  -------  ---------------------------------------------  ---------
//  in       in_valid, in_stall, command, task_id,          into block
//           user_id, priority_req
//  out      out_valid, out_stall, owner, none_left         out of block
//
//  Add and an edit of a present task do a slot RAM read, a removal shift
//  and an insert shift; remove, an edit of an absent task and execute-top
//  do a slot RAM read and one removal or pop step; an id beyond the slots
//  is dropped. The slot RAM read is registered and the chain makes one shift
//  per cycle; execute-top waits while a previous result word is stalled.
//  Reset clears the cells and the slot valid bits at once; no clearing pass.
//  A result word waits in the output register while the next word is taken.
//
`default_nettype none

module addressable_task_priority_queue_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [atpq_pkg::CMD_W-1:0]     command,
    input  wire logic [atpq_pkg::ID_W-1:0]      task_id,
    input  wire logic [atpq_pkg::OWNER_W-1:0]   user_id,
    input  wire logic [atpq_pkg::PRIO_W-1:0]    priority_req,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [atpq_pkg::OWNER_W-1:0]   owner,
    output logic                                none_left
);

    import atpq_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_REMOVE = 4'b0010,
        ST_INSERT = 4'b0100,
        ST_EXEC   = 4'b1000
    } state_t;

    localparam int unsigned RAM_W = OWNER_W + PRIO_W;

    state_t                state_reg;
    state_t                state_next;
    cmd_t                  cmd_reg;
    logic [SLOT_AW-1:0]    id_reg;
    logic [OWNER_W-1:0]    user_reg;
    logic [PRIO_W-1:0]     prio_reg;
    logic [OWNER_W-1:0]    ins_owner_reg;
    logic [OWNER_W-1:0]    ins_owner_next;
    logic [TASK_SLOTS-1:0] slot_valid_reg;
    logic [TASK_SLOTS-1:0] slot_valid_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OWNER_W-1:0]    owner_reg;
    logic                  none_left_reg;

    logic                  accept;
    logic                  id_in_range;
    logic                  present;
    logic                  out_load;
    logic                  ram_we;
    logic [RAM_W-1:0]      ram_rdata;
    logic [OWNER_W-1:0]    rd_owner;
    logic [PRIO_W-1:0]     rd_prio;
    chain_op_t             ch_op;
    entry_t                head;

    assign in_stall    = (state_reg != ST_IDLE);
    assign accept      = in_valid && !in_stall;
    assign id_in_range = (32'(task_id) < TASK_SLOTS);
    assign present     = slot_valid_reg[id_reg];
    assign rd_owner    = ram_rdata[PRIO_W +: OWNER_W];
    assign rd_prio     = ram_rdata[PRIO_W-1:0];
    assign out_load    = (state_reg == ST_EXEC) && (!out_valid_reg || !out_stall);
    assign ram_we      = (state_reg == ST_INSERT);

    // Slot RAM: read on acceptance, written when the task is inserted.
    atpq_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TASK_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (id_reg),
        .wdata ({ins_owner_reg, prio_reg}),
        .re    (accept),
        .raddr (SLOT_AW'(task_id)),
        .rdata (ram_rdata)
    );

    // Sorted chain of cells.
    atpq_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (ch_op),
        .head  (head)
    );

    // Sequencer, chain operation and slot valid updates.
    always_comb
    begin
        state_next      = state_reg;
        ins_owner_next  = ins_owner_reg;
        slot_valid_next = slot_valid_reg;
        ch_op.kind      = CH_HOLD;
        ch_op.prio      = prio_reg;
        ch_op.id        = id_reg;
        ch_op.owner     = ins_owner_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd_t'(command) == CMD_EXEC)
                    begin
                        state_next = ST_EXEC;
                    end
                    else if (id_in_range)
                    begin
                        state_next = ST_REMOVE;
                    end
                end
            end
            ST_REMOVE:
            begin
                // Take the old copy out of the chain by its stored key.
                if (present)
                begin
                    ch_op.kind = CH_REMOVE;
                    ch_op.prio = rd_prio;
                end
                unique case (cmd_reg)
                    CMD_ADD:
                    begin
                        ins_owner_next = user_reg;
                        state_next     = ST_INSERT;
                    end
                    CMD_EDIT:
                    begin
                        ins_owner_next = rd_owner;
                        state_next     = present ? ST_INSERT : ST_IDLE;
                    end
                    default:
                    begin
                        slot_valid_next[id_reg] = 1'b0;
                        state_next              = ST_IDLE;
                    end
                endcase
            end
            ST_INSERT:
            begin
                ch_op.kind              = CH_INSERT;
                slot_valid_next[id_reg] = 1'b1;
                state_next              = ST_IDLE;
            end
            ST_EXEC:
            begin
                if (out_load)
                begin
                    if (head.valid)
                    begin
                        ch_op.kind               = CH_POP;
                        slot_valid_next[head.id] = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output word valid: set on load, cleared once taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            slot_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            slot_valid_reg <= slot_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Captured input word and insert owner.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd_t'(command);
            id_reg   <= SLOT_AW'(task_id);
            user_reg <= user_id;
            prio_reg <= priority_req;
        end
        ins_owner_reg <= ins_owner_next;
    end

    // Result word register.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            owner_reg     <= head.valid ? head.owner : '0;
            none_left_reg <= !head.valid;
        end
    end

    assign out_valid = out_valid_reg;
    assign owner     = owner_reg;
    assign none_left = none_left_reg;

endmodule

`default_nettype wire
